// ===== hw/rtl/sdsl_pkg.sv =====
// Shared types, codes and helpers for the sprite depth sort list.
package sdsl_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam int unsigned QUEUE_DEPTH     = 2;

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_DRAIN   = 2'd1,
    KIND_DRAIN_C = 2'd2,
    KIND_FLUSH   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_DRAWN    = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic {
    BK_IDLE  = 1'b0,
    BK_DRAIN = 1'b1
  } bk_state_t;

  // One stored draw entry, with its precomputed bottom edge
  typedef struct packed {
    logic [15:0]        image;
    logic [7:0]         layer;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] src_x;
    logic signed [15:0] src_y;
    logic [14:0]        width;
    logic [14:0]        height;
    logic signed [16:0] bottom;
  } entry_t;

  // One classified command as it travels from front to back
  typedef struct packed {
    kind_t              kind;
    entry_t             ent;
    logic signed [17:0] off_x;
    logic signed [17:0] off_y;
  } cmd_t;

  // Clamp a difference to the 17-bit signed result range
  function automatic logic signed [16:0] sat17(input logic signed [18:0] v);
    logic signed [16:0] r;
    if (v > 19'sd65535) begin
      r = 17'sd65535;
    end else if (v < -19'sd65536) begin
      r = -17'sd65536;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/sdsl_front.sv =====
// Front end: classifies input transactions and queues them for the list engine.
module sdsl_front
  import sdsl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic signed [15:0] in_x_pos,
  input  logic signed [15:0] in_y_pos,
  input  logic signed [15:0] in_src_x,
  input  logic signed [15:0] in_src_y,
  input  logic [14:0]        in_width,
  input  logic [14:0]        in_height,
  input  logic [7:0]         in_layer_num,
  input  logic [15:0]        in_image_handle,
  input  logic [11:0]        window_width,
  input  logic [11:0]        window_height,
  output logic               q_valid,
  output cmd_t               q_cmd,
  input  logic               q_pop
);

  cmd_t       cmd;
  cmd_t       slot_r [QUEUE_DEPTH];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  // Classify: bottom edge for inserts, centring offset for centred drains
  always_comb begin
    cmd.kind         = kind_t'(in_kind);
    cmd.ent.image    = in_image_handle;
    cmd.ent.layer    = in_layer_num;
    cmd.ent.x        = in_x_pos;
    cmd.ent.y        = in_y_pos;
    cmd.ent.src_x    = in_src_x;
    cmd.ent.src_y    = in_src_y;
    cmd.ent.width    = in_width;
    cmd.ent.height   = in_height;
    cmd.ent.bottom   = {in_y_pos[15], in_y_pos} + $signed({2'b00, in_height});
    if (kind_t'(in_kind) == KIND_DRAIN_C) begin
      cmd.off_x = {{2{in_x_pos[15]}}, in_x_pos} - $signed({7'd0, window_width[11:1]});
      cmd.off_y = {{2{in_y_pos[15]}}, in_y_pos} - $signed({7'd0, window_height[11:1]});
    end else begin
      cmd.off_x = '0;
      cmd.off_y = '0;
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = slot_r[rd_ptr_r];

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd;
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== hw/rtl/sdsl_back.sv =====
// Back end: sorted entry list with parallel insert and shift-out drain.
module sdsl_back
  import sdsl_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [15:0]        out_image,
  output logic signed [16:0] out_x,
  output logic signed [16:0] out_y,
  output logic signed [15:0] out_src_x,
  output logic signed [15:0] out_src_y,
  output logic [14:0]        out_width,
  output logic [14:0]        out_height,
  output logic               out_last
);

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  bk_state_t          state_r, state_nxt;
  entry_t             list_r [MAX_ENTRIES];
  logic [CW-1:0]      count_r;
  logic signed [17:0] off_x_r, off_y_r;
  logic               out_valid_r;
  logic               adv, full;
  logic               do_insert, do_shift, do_flush, do_result, start_drain;
  status_t            res_status;
  logic [MAX_ENTRIES-1:0] place;

  assign adv  = !out_valid_r || out_ready;
  assign full = (count_r == CW'(MAX_ENTRIES));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && adv && count_r != '0 &&
            (q_cmd.kind == KIND_DRAIN || q_cmd.kind == KIND_DRAIN_C)) begin
          state_nxt = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (adv && count_r == CW'(1)) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop       = 1'b0;
    do_insert   = 1'b0;
    do_shift    = 1'b0;
    do_flush    = 1'b0;
    do_result   = 1'b0;
    start_drain = 1'b0;
    res_status  = ST_INSERTED;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && adv) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            KIND_INSERT: begin
              do_result  = 1'b1;
              do_insert  = !full;
              res_status = full ? ST_FULL : ST_INSERTED;
            end
            KIND_DRAIN, KIND_DRAIN_C: begin
              if (count_r == '0) begin
                do_result  = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                start_drain = 1'b1;
              end
            end
            KIND_FLUSH: do_flush = 1'b1;
            default: do_flush = 1'b1;
          endcase
        end
      end
      BK_DRAIN: begin
        if (adv) begin
          do_shift   = 1'b1;
          res_status = ST_DRAWN;
        end
      end
      default: ;
    endcase
  end

  // Find slots at or after the insert position
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (CW'(i) < count_r) begin
        place[i] = (list_r[i].layer > q_cmd.ent.layer) ||
                   (list_r[i].layer == q_cmd.ent.layer &&
                    list_r[i].bottom >= q_cmd.ent.bottom);
      end else begin
        place[i] = (CW'(i) == count_r);
      end
    end
  end

  // Shift the list up on insert, down on drain
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (do_insert) begin
        if (i > 0 && place[(i > 0) ? i - 1 : 0]) begin
          list_r[i] <= list_r[(i > 0) ? i - 1 : 0];
        end else if (place[i]) begin
          list_r[i] <= q_cmd.ent;
        end
      end else if (do_shift && i < MAX_ENTRIES - 1) begin
        list_r[i] <= list_r[(i < MAX_ENTRIES - 1) ? i + 1 : i];
      end
    end
  end

  // Track state, fill count and drain offsets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (do_flush) count_r <= '0;
      else if (do_insert) count_r <= count_r + CW'(1);
      else if (do_shift) count_r <= count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start_drain) begin
      off_x_r <= q_cmd.off_x;
      off_y_r <= q_cmd.off_y;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= do_result || do_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (do_shift) begin
      out_status <= res_status;
      out_image  <= list_r[0].image;
      out_x      <= sat17({{3{list_r[0].x[15]}}, list_r[0].x} - {off_x_r[17], off_x_r});
      out_y      <= sat17({{3{list_r[0].y[15]}}, list_r[0].y} - {off_y_r[17], off_y_r});
      out_src_x  <= list_r[0].src_x;
      out_src_y  <= list_r[0].src_y;
      out_width  <= list_r[0].width;
      out_height <= list_r[0].height;
      out_last   <= (count_r == CW'(1));
    end else if (do_result) begin
      out_status <= res_status;
      out_image  <= '0;
      out_x      <= '0;
      out_y      <= '0;
      out_src_x  <= '0;
      out_src_y  <= '0;
      out_width  <= '0;
      out_height <= '0;
      out_last   <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/sprite_depth_sort_list.sv =====
// Top level of the sprite depth sort list: register port, front end and list engine.
// Keeps up to MAX_ENTRIES sprite entries sorted by layer, then bottom edge (y + height);
// a new entry lands ahead of equal keys. An insert, a flush or an empty drain is
// handled in the list engine once it leaves the two-entry command queue; a drain
// first latches the centring offset and then moves one entry per cycle, while the
// output is not stalled, as the list shifts into the single output register.
// Inserts compare against every stored entry at once. Window size registers sit at
// byte addresses 0 and 4.
module sprite_depth_sort_list
  import sdsl_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic signed [15:0] in_x_pos,
  input  logic signed [15:0] in_y_pos,
  input  logic signed [15:0] in_src_x,
  input  logic signed [15:0] in_src_y,
  input  logic [14:0]        in_width,
  input  logic [14:0]        in_height,
  input  logic [7:0]         in_layer_num,
  input  logic [15:0]        in_image_handle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [15:0]        out_image,
  output logic signed [16:0] out_x,
  output logic signed [16:0] out_y,
  output logic signed [15:0] out_src_x,
  output logic signed [15:0] out_src_y,
  output logic [14:0]        out_width,
  output logic [14:0]        out_height,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [11:0] win_w_r, win_h_r;
  logic        q_valid, q_pop;
  cmd_t        q_cmd;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {20'd0, win_h_r} : {20'd0, win_w_r};

  // Write window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_w_r <= 12'd640;
      win_h_r <= 12'd480;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) win_h_r <= pwdata[11:0];
      else          win_w_r <= pwdata[11:0];
    end
  end

  sdsl_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_x_pos, .in_y_pos,
    .in_src_x, .in_src_y, .in_width, .in_height, .in_layer_num, .in_image_handle,
    .window_width(win_w_r), .window_height(win_h_r),
    .q_valid, .q_cmd, .q_pop
  );

  sdsl_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_pop,
    .out_valid, .out_ready, .out_status, .out_image, .out_x, .out_y,
    .out_src_x, .out_src_y, .out_width, .out_height, .out_last
  );

endmodule

// ===== hw/rtl/sdsl_chk.sv =====
// Port-level checker for the sprite depth sort list, bound to the top level.
module sdsl_chk
  import sdsl_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic [15:0]        out_image,
  input logic signed [16:0] out_x,
  input logic               out_last
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Insert acknowledgements are single results
  a_ins_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_INSERTED || out_status == ST_FULL) |-> out_last)
    else $error("insert result without last");

  // Empty drain carries no entry
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_last && out_image == '0 && out_x == '0)
    else $error("empty drain with payload");

  // A drained entry that is not last is followed by another drawn entry
  a_drain_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_status == ST_DRAWN && !out_last
    |=> !out_valid || out_status == ST_DRAWN)
    else $error("drain interrupted");

endmodule

bind sprite_depth_sort_list sdsl_chk u_chk (
  .clk, .rst_n, .out_valid, .out_ready, .out_status, .out_image, .out_x, .out_last
);
